/* hw/rtl/dlfc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlfc_pkg
// shared types and constants of the display link framer and checker
// ----------------------------------------------------------------------------
package dlfc_pkg;

   localparam int BYTE_W    = 8;
   localparam int CNT_W     = 6;
   localparam int RX_POS_W  = 9;
   localparam int KIND_W    = 2;
   localparam int STAT_W    = 2;
   localparam int CSR_IDX_W = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SEND_CTRL    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REQUEST_CTRL = 2'd1;

   localparam logic [BYTE_W-1:0] SEND_CTRL_RESET    = 8'd17;
   localparam logic [BYTE_W-1:0] REQUEST_CTRL_RESET = 8'd18;

   // request types
   localparam logic REQ_TX = 1'b0;
   localparam logic REQ_RX = 1'b1;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_LINE      = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RX_PAY    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RX_STATUS = 2'd2;

   // status codes
   localparam logic [STAT_W-1:0] STAT_GOOD    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_BAD_SUM = 2'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd2;
   localparam logic [STAT_W-1:0] STAT_TX_OVF  = 2'd3;

   typedef enum logic [2:0] {
      SEL_RX   = 3'd0,
      SEL_CTRL = 3'd1,
      SEL_LEN  = 3'd2,
      SEL_PAY  = 3'd3,
      SEL_CHK  = 3'd4
   } out_sel_type;

   typedef struct packed {
      logic        tx_accept;
      logic        rx_accept;
      logic        out_load;
      out_sel_type out_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
      logic rx_result;
      logic count_zero;
      logic pay_last;
   } dp_status_type;

endpackage

/* hw/rtl/dlfc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlfc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module dlfc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/dlfc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlfc_ctrl
// controller: request acceptance and transmit frame emission sequence
// ----------------------------------------------------------------------------
module dlfc_ctrl
   import dlfc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_type,
   input  logic          req_last,
   output logic          req_stall,
   input  dp_status_type dp_status,
   output dp_cmd_type    dp_cmd
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_CTRL = 5'b00010,
      ST_LEN  = 5'b00100,
      ST_PAY  = 5'b01000,
      ST_CHK  = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      req_accept;

   assign req_stall  = (state_ff != ST_IDLE) || !dp_status.out_free;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      state_in          = state_ff;
      dp_cmd.tx_accept  = 1'b0;
      dp_cmd.rx_accept  = 1'b0;
      dp_cmd.out_load   = 1'b0;
      dp_cmd.out_sel    = SEL_RX;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_type == REQ_TX) begin
                  dp_cmd.tx_accept = 1'b1;
                  if (req_last) begin
                     state_in = ST_CTRL;
                  end
               end else begin
                  dp_cmd.rx_accept = 1'b1;
                  dp_cmd.out_load  = dp_status.rx_result;
               end
            end
         end
         ST_CTRL: begin
            dp_cmd.out_sel = SEL_CTRL;
            if (dp_status.out_free) begin
               dp_cmd.out_load = 1'b1;
               state_in        = ST_LEN;
            end
         end
         ST_LEN: begin
            dp_cmd.out_sel = SEL_LEN;
            if (dp_status.out_free) begin
               dp_cmd.out_load = 1'b1;
               state_in        = dp_status.count_zero ? ST_CHK : ST_PAY;
            end
         end
         ST_PAY: begin
            dp_cmd.out_sel = SEL_PAY;
            if (dp_status.out_free) begin
               dp_cmd.out_load = 1'b1;
               state_in        = dp_status.pay_last ? ST_CHK : ST_PAY;
            end
         end
         ST_CHK: begin
            dp_cmd.out_sel = SEL_CHK;
            if (dp_status.out_free) begin
               dp_cmd.out_load = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_last_starts_frame: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_type == REQ_TX && req_last) |=> state_ff == ST_CTRL)
      else $error("last transmit request did not start frame emission");

   a_chk_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHK && dp_status.out_free) |=> state_ff == ST_IDLE)
      else $error("controller did not return to idle after checksum");

   a_no_load_in_emit_without_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && !dp_status.out_free) |=> $stable(state_ff))
      else $error("emission advanced while output register was full");
`endif

endmodule

/* hw/rtl/dlfc_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlfc_datapath
// transmit buffer, checksums, receive tracking, config and output register
// ----------------------------------------------------------------------------
module dlfc_datapath
   import dlfc_pkg::*;
#(
   parameter int MAX_PAYLOAD = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [BYTE_W-1:0]    req_data_byte,
   input  logic                 req_last,
   input  logic                 req_want_reply,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [KIND_W-1:0]    rsp_out_kind,
   output logic [BYTE_W-1:0]    rsp_out_byte,
   output logic [STAT_W-1:0]    rsp_status,
   output logic                 rsp_frame_end,
   input  dp_cmd_type           dp_cmd,
   output dp_status_type        dp_status
);

   localparam int AddrW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_PAYLOAD);

   // config registers
   logic [BYTE_W-1:0] send_ctrl_ff;
   logic [BYTE_W-1:0] request_ctrl_ff;

   // transmit accumulation
   logic [CNT_W-1:0]  tx_count_ff;
   logic [BYTE_W-1:0] tx_sum_ff;
   logic              tx_ovf_ff;
   logic              tx_full;
   logic [CNT_W-1:0]  tx_count_in;
   logic [BYTE_W-1:0] tx_sum_in;

   // frame being emitted
   logic [BYTE_W-1:0] frame_ctrl_ff;
   logic [CNT_W-1:0]  frame_cnt_ff;
   logic [BYTE_W-1:0] frame_chk_ff;
   logic [STAT_W-1:0] frame_st_ff;
   logic [BYTE_W-1:0] ctrl_sel;
   logic [CNT_W-1:0]  pay_idx_ff;
   logic [CNT_W-1:0]  pay_idx_next;

   // receive tracking
   logic [RX_POS_W-1:0] rx_pos_ff;
   logic [BYTE_W-1:0]   rx_len_ff;
   logic [BYTE_W-1:0]   rx_sum_ff;
   logic [RX_POS_W-1:0] rx_pay_end;
   logic                rx_in_payload;
   logic [STAT_W-1:0]   rx_close_st;

   // payload buffer
   logic             ram_wr_en;
   logic             ram_rd_en;
   logic [AddrW-1:0] ram_rd_addr;
   logic [BYTE_W-1:0] ram_rd_data;

   // output register
   logic              out_valid_ff;
   logic [KIND_W-1:0] out_kind_ff;
   logic [BYTE_W-1:0] out_byte_ff;
   logic [STAT_W-1:0] out_st_ff;
   logic              out_end_ff;
   logic              out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         send_ctrl_ff    <= SEND_CTRL_RESET;
         request_ctrl_ff <= REQUEST_CTRL_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_SEND_CTRL) begin
            send_ctrl_ff <= csr_data;
         end
         if (csr_index == CSR_REQUEST_CTRL) begin
            request_ctrl_ff <= csr_data;
         end
      end
   end

   // ---- transmit side ----
   assign tx_full     = (tx_count_ff == MaxCnt);
   assign tx_count_in = tx_full ? tx_count_ff : CNT_W'(tx_count_ff + CNT_W'(1));
   assign tx_sum_in   = tx_full ? tx_sum_ff : BYTE_W'(tx_sum_ff + req_data_byte);
   assign ctrl_sel    = req_want_reply ? request_ctrl_ff : send_ctrl_ff;
   assign ram_wr_en   = dp_cmd.tx_accept && !tx_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_count_ff <= '0;
         tx_sum_ff   <= '0;
         tx_ovf_ff   <= 1'b0;
      end else if (dp_cmd.tx_accept) begin
         if (req_last) begin
            tx_count_ff <= '0;
            tx_sum_ff   <= '0;
            tx_ovf_ff   <= 1'b0;
         end else begin
            tx_count_ff <= tx_count_in;
            tx_sum_ff   <= tx_sum_in;
            tx_ovf_ff   <= tx_ovf_ff | tx_full;
         end
      end
   end

   // frame snapshot taken with the last transmit byte
   always_ff @(posedge clock) begin
      if (dp_cmd.tx_accept && req_last) begin
         frame_ctrl_ff <= ctrl_sel;
         frame_cnt_ff  <= tx_count_in;
         frame_chk_ff  <= BYTE_W'(ctrl_sel + {{(BYTE_W-CNT_W){1'b0}}, tx_count_in} + tx_sum_in);
         frame_st_ff   <= (tx_ovf_ff | tx_full) ? STAT_TX_OVF : STAT_GOOD;
      end
   end

   // payload read runs one step ahead of the output register
   assign pay_idx_next = CNT_W'(pay_idx_ff + CNT_W'(1));
   assign dp_status.pay_last   = (pay_idx_next == frame_cnt_ff);
   assign dp_status.count_zero = (frame_cnt_ff == '0);

   always_comb begin
      ram_rd_en   = 1'b0;
      ram_rd_addr = '0;
      if (dp_cmd.out_load && dp_cmd.out_sel == SEL_LEN) begin
         ram_rd_en = !dp_status.count_zero;
      end else if (dp_cmd.out_load && dp_cmd.out_sel == SEL_PAY) begin
         ram_rd_en   = !dp_status.pay_last;
         ram_rd_addr = pay_idx_next[AddrW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.out_load && dp_cmd.out_sel == SEL_LEN) begin
         pay_idx_ff <= '0;
      end else if (dp_cmd.out_load && dp_cmd.out_sel == SEL_PAY) begin
         pay_idx_ff <= pay_idx_next;
      end
   end

   dlfc_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_PAYLOAD)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tx_count_ff[AddrW-1:0]),
      .wr_data (req_data_byte),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ---- receive side ----
   assign rx_pay_end    = RX_POS_W'({1'b0, rx_len_ff} + RX_POS_W'(2));
   assign rx_in_payload = (rx_pos_ff < rx_pay_end);
   assign dp_status.rx_result = (rx_pos_ff > RX_POS_W'(1));

   always_comb begin
      if (rx_len_ff == '0) begin
         rx_close_st = STAT_EMPTY;
      end else if (rx_sum_ff != req_data_byte) begin
         rx_close_st = STAT_BAD_SUM;
      end else begin
         rx_close_st = STAT_GOOD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_pos_ff <= '0;
         rx_len_ff <= '0;
         rx_sum_ff <= '0;
      end else if (dp_cmd.rx_accept) begin
         if (rx_pos_ff == '0) begin
            rx_sum_ff <= req_data_byte;
            rx_pos_ff <= RX_POS_W'(1);
         end else if (rx_pos_ff == RX_POS_W'(1)) begin
            rx_len_ff <= req_data_byte;
            rx_sum_ff <= BYTE_W'(rx_sum_ff + req_data_byte);
            rx_pos_ff <= RX_POS_W'(2);
         end else if (rx_in_payload) begin
            rx_sum_ff <= BYTE_W'(rx_sum_ff + req_data_byte);
            rx_pos_ff <= RX_POS_W'(rx_pos_ff + RX_POS_W'(1));
         end else begin
            rx_pos_ff <= '0;
            rx_len_ff <= '0;
            rx_sum_ff <= '0;
         end
      end
   end

   // ---- output register ----
   assign out_free           = !out_valid_ff || !rsp_stall;
   assign dp_status.out_free = out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (dp_cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.out_load) begin
         case (dp_cmd.out_sel)
            SEL_RX: begin
               if (rx_in_payload) begin
                  out_kind_ff <= KIND_RX_PAY;
                  out_byte_ff <= req_data_byte;
                  out_st_ff   <= STAT_GOOD;
                  out_end_ff  <= 1'b0;
               end else begin
                  out_kind_ff <= KIND_RX_STATUS;
                  out_byte_ff <= rx_len_ff;
                  out_st_ff   <= rx_close_st;
                  out_end_ff  <= 1'b1;
               end
            end
            SEL_CTRL: begin
               out_kind_ff <= KIND_LINE;
               out_byte_ff <= frame_ctrl_ff;
               out_st_ff   <= frame_st_ff;
               out_end_ff  <= 1'b0;
            end
            SEL_LEN: begin
               out_kind_ff <= KIND_LINE;
               out_byte_ff <= {{(BYTE_W-CNT_W){1'b0}}, frame_cnt_ff};
               out_st_ff   <= frame_st_ff;
               out_end_ff  <= 1'b0;
            end
            SEL_PAY: begin
               out_kind_ff <= KIND_LINE;
               out_byte_ff <= ram_rd_data;
               out_st_ff   <= frame_st_ff;
               out_end_ff  <= 1'b0;
            end
            SEL_CHK: begin
               out_kind_ff <= KIND_LINE;
               out_byte_ff <= frame_chk_ff;
               out_st_ff   <= frame_st_ff;
               out_end_ff  <= 1'b1;
            end
            default: begin
               out_kind_ff <= KIND_LINE;
               out_byte_ff <= frame_chk_ff;
               out_st_ff   <= frame_st_ff;
               out_end_ff  <= 1'b1;
            end
         endcase
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_kind  = out_kind_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_status    = out_st_ff;
   assign rsp_frame_end = out_end_ff;

`ifndef SYNTHESIS
   a_tx_count_bounded: assert property (@(posedge clock) disable iff (reset)
      tx_count_ff <= MaxCnt)
      else $error("transmit count exceeds buffer depth");

   a_pay_read_in_frame: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.out_load && dp_cmd.out_sel == SEL_PAY) |-> pay_idx_ff < frame_cnt_ff)
      else $error("payload index beyond frame length");

   a_rx_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      (rx_pos_ff > RX_POS_W'(1)) |-> rx_pos_ff <= rx_pay_end)
      else $error("receive position beyond checksum byte");
`endif

endmodule

/* hw/rtl/display_link_framer_checker_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// display_link_framer_checker_top
// serial display link framer (transmit) and frame checker (receive)
// ----------------------------------------------------------------------------
// Transmit payload bytes and received line bytes are taken one request per
// cycle while the controller is idle and the output register has room. A
// received byte gives at most one result, and a request is taken in the same
// cycle as the previous result leaves the output register. The transmit
// request marked last starts emission of the frame: control byte, length,
// payload and checksum, one line byte per cycle unless the output stalls, from
// the single output register and the one read port of the payload buffer;
// requests are held off until the checksum byte has been loaded. No clearing
// pass is run after reset; configuration writes are taken in any cycle.
module display_link_framer_checker_top
   import dlfc_pkg::*;
#(
   parameter int MAX_PAYLOAD = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_type,
   input  logic [BYTE_W-1:0]    req_data_byte,
   input  logic                 req_last,
   input  logic                 req_want_reply,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [KIND_W-1:0]    rsp_out_kind,
   output logic [BYTE_W-1:0]    rsp_out_byte,
   output logic [STAT_W-1:0]    rsp_status,
   output logic                 rsp_frame_end,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_data
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   assign csr_ready = 1'b1;

   dlfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_last  (req_last),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   dlfc_datapath #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_data_byte  (req_data_byte),
      .req_last       (req_last),
      .req_want_reply (req_want_reply),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_kind   (rsp_out_kind),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_status     (rsp_status),
      .rsp_frame_end  (rsp_frame_end),
      .dp_cmd         (dp_cmd),
      .dp_status      (dp_status)
   );

endmodule
